// ===== hw/rtl/bli_pkg.sv =====
package bli_pkg;

    // Table geometry and field widths
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int NUM_W      = 5;
    localparam int TIME_W     = 16;
    localparam int LEVEL_W    = 24;

    // Datapath widths for the interpolation arithmetic
    localparam int DT_W   = TIME_W + 1;
    localparam int DV_W   = LEVEL_W + 1;
    localparam int PROD_W = DT_W + DV_W;
    localparam int MAG_W  = PROD_W - 1;
    localparam int CNT_W  = $clog2(MAG_W + 1);
    localparam int SUM_W  = PROD_W + 1;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic [3:0]                 point_index;
        logic [TIME_W-1:0]          point_time;
        logic signed [LEVEL_W-1:0]  point_value;
        logic [TIME_W-1:0]          eval_time;
        logic                       end_of_block;
    } req_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0]  level;
        logic [3:0]                 segment;
        logic                       block_last;
    } rsp_t;

    // One breakpoint as stored in the table
    typedef struct packed {
        logic [TIME_W-1:0]          pt_time;
        logic signed [LEVEL_W-1:0]  pt_level;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SETUP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT
    } state_t;

endpackage

// ===== hw/rtl/bli_table.sv =====
module bli_table (
    input  logic                        clk,
    input  logic                        we,
    input  logic [bli_pkg::IDX_W-1:0]   waddr,
    input  bli_pkg::entry_t             wdata,
    input  logic [bli_pkg::IDX_W-1:0]   raddr_a,
    input  logic [bli_pkg::IDX_W-1:0]   raddr_b,
    output bli_pkg::entry_t             rdata_a,
    output bli_pkg::entry_t             rdata_b
);
    import bli_pkg::*;

    entry_t mem [MAX_POINTS];

    // Write one breakpoint
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register both read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hw/rtl/bli_div.sv =====
module bli_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [bli_pkg::PROD_W-1:0]   dividend,
    input  logic signed [bli_pkg::DT_W-1:0]     divisor,
    output logic                                done,
    output logic signed [bli_pkg::PROD_W-1:0]   quotient
);
    import bli_pkg::*;

    localparam int DVS_MAG_W = DT_W - 1;

    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       neg_reg, neg_next;
    logic [MAG_W-1:0]           quo_reg, quo_next;
    logic [DVS_MAG_W:0]         rem_reg, rem_next;
    logic [DVS_MAG_W-1:0]       dvs_reg, dvs_next;

    logic signed [PROD_W-1:0]   dvd_abs;
    logic signed [DT_W-1:0]     dvs_abs;
    logic [DVS_MAG_W:0]         trial;
    logic [PROD_W-1:0]          quo_ext;

    // Take magnitudes of the operands
    assign dvd_abs = dividend[PROD_W-1] ? -dividend : dividend;
    assign dvs_abs = divisor[DT_W-1] ? -divisor : divisor;

    // Shift in the next dividend bit
    assign trial = {rem_reg[DVS_MAG_W-1:0], quo_reg[MAG_W-1]};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            neg_next = dividend[PROD_W-1] ^ divisor[DT_W-1];
            quo_next = dvd_abs[MAG_W-1:0];
            rem_next = '0;
            dvs_next = dvs_abs[DVS_MAG_W-1:0];
        end
        else if (run_reg)
        begin
            // One restoring step per cycle
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // Apply the sign, truncating toward zero
    assign quo_ext  = {1'b0, quo_reg};
    assign quotient = neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
    assign done     = done_reg;

endmodule

// ===== hw/rtl/breakpoint_linear_interpolator_top.sv =====
// Breakpoint envelope generator with linear interpolation.
// Command channel: a word on req is taken at a clock edge where start is high
// and busy is low. A load word writes one (time, level) pair into the
// 16-entry table in that same cycle; it yields no result and busy stays low.
// An evaluate word raises busy while a sequencer walks the table segment by
// segment, read then compare, to find the first one whose end time is at least the
// evaluation time (else the last segment in use), then interpolates.
// Result channel: result_valid is high for exactly one cycle with the word on
// result; the receiver cannot stall, so each result is taken in that cycle.
// An evaluate examines 1 to 15 segments, then a setup step; an exact hit on a
// breakpoint or a zero-length segment returns its level from setup, otherwise
// the product is formed, then the restoring divider is started and run to its end.
// The block takes one evaluate at a time; the next may start in the cycle
// its result is shown.
// The user must write num_points through cfg_wr_en/cfg_wr_data only while idle;
// the block has no check for it. Reset: num_points returns to 2 and the
// sequencer to idle; table contents are undefined until loaded.
module breakpoint_linear_interpolator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  bli_pkg::req_t                   req,
    output logic                            busy,
    output logic                            result_valid,
    output bli_pkg::rsp_t                   result,
    input  logic                            cfg_wr_en,
    input  logic [bli_pkg::NUM_W-1:0]       cfg_wr_data
);
    import bli_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - LEVEL_W + 1){1'b0}}, {(LEVEL_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    state_t                     state_reg, state_next;
    logic [NUM_W-1:0]           num_reg;
    logic [IDX_W-1:0]           seg_reg, seg_next;
    logic [TIME_W-1:0]          time_reg, time_next;
    logic                       eob_reg, eob_next;
    logic signed [DT_W-1:0]     dt_reg, dt_next;
    logic signed [DV_W-1:0]     dv_reg, dv_next;
    logic signed [DT_W-1:0]     dvs_reg, dvs_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [LEVEL_W-1:0]  v0_reg, v0_next;
    logic                       valid_reg, valid_next;
    rsp_t                       result_reg, result_next;

    logic [IDX_W-1:0]           last_seg;
    logic                       mem_we;
    entry_t                     mem_wdata;
    entry_t                     rd_a, rd_b;
    logic                       div_start;
    logic                       div_done;
    logic signed [PROD_W-1:0]   div_quo;
    logic signed [SUM_W-1:0]    sum;
    logic signed [LEVEL_W-1:0]  sat_level;

    // Index of the last segment in use, with num_points clamped to range
    always_comb
    begin
        if (num_reg < NUM_W'(2))
        begin
            last_seg = '0;
        end
        else if (num_reg > NUM_W'(MAX_POINTS))
        begin
            last_seg = IDX_W'(MAX_POINTS - 2);
        end
        else
        begin
            last_seg = IDX_W'(num_reg - NUM_W'(2));
        end
    end

    assign mem_wdata = '{pt_time: req.point_time, pt_level: req.point_value};

    bli_table u_table (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (req.point_index[IDX_W-1:0]),
        .wdata   (mem_wdata),
        .raddr_a (seg_reg),
        .raddr_b (seg_reg + 1'b1),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    bli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Add the start level to the quotient and saturate
    assign sum = {{(SUM_W - LEVEL_W){v0_reg[LEVEL_W-1]}}, v0_reg}
               + {div_quo[PROD_W-1], div_quo};

    always_comb
    begin
        if (sum > SAT_HI)
        begin
            sat_level = SAT_HI[LEVEL_W-1:0];
        end
        else if (sum < SAT_LO)
        begin
            sat_level = SAT_LO[LEVEL_W-1:0];
        end
        else
        begin
            sat_level = sum[LEVEL_W-1:0];
        end
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next  = state_reg;
        seg_next    = seg_reg;
        time_next   = time_reg;
        eob_next    = eob_reg;
        dt_next     = dt_reg;
        dv_next     = dv_reg;
        dvs_next    = dvs_reg;
        prod_next   = prod_reg;
        v0_next     = v0_reg;
        valid_next  = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type == REQ_LOAD)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        time_next  = req.eval_time;
                        eob_next   = req.end_of_block;
                        seg_next   = '0;
                        state_next = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_RD:
            begin
                // Wait for the table read of this segment
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (seg_reg == last_seg || rd_b.pt_time >= time_reg)
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    seg_next   = seg_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SETUP:
            begin
                if (time_reg == rd_a.pt_time || rd_a.pt_time == rd_b.pt_time)
                begin
                    // Hit on the start point or a zero-length segment
                    valid_next  = 1'b1;
                    result_next = '{level: rd_a.pt_level, segment: 4'(seg_reg),
                                    block_last: eob_reg};
                    state_next  = ST_IDLE;
                end
                else if (time_reg == rd_b.pt_time)
                begin
                    // Hit on the end point
                    valid_next  = 1'b1;
                    result_next = '{level: rd_b.pt_level, segment: 4'(seg_reg),
                                    block_last: eob_reg};
                    state_next  = ST_IDLE;
                end
                else
                begin
                    dt_next    = $signed({1'b0, time_reg}) - $signed({1'b0, rd_a.pt_time});
                    dvs_next   = $signed({1'b0, rd_b.pt_time})
                               - $signed({1'b0, rd_a.pt_time});
                    dv_next    = $signed({rd_b.pt_level[LEVEL_W-1], rd_b.pt_level})
                               - $signed({rd_a.pt_level[LEVEL_W-1], rd_a.pt_level});
                    v0_next    = rd_a.pt_level;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = dt_reg * dv_reg;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    valid_next  = 1'b1;
                    result_next = '{level: sat_level, segment: 4'(seg_reg),
                                    block_last: eob_reg};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            num_reg   <= NUM_W'(2);
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_wr_en)
            begin
                num_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        seg_reg    <= seg_next;
        time_reg   <= time_next;
        eob_reg    <= eob_next;
        dt_reg     <= dt_next;
        dv_reg     <= dv_next;
        dvs_reg    <= dvs_next;
        prod_reg   <= prod_next;
        v0_reg     <= v0_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule
